[rtl/bts_pkg.sv]
// Shared types and constants for the bilinear texture sampler.
package bts_pkg;

   localparam int CFG_W   = 9;
   localparam int COORD_W = 16;
   localparam int CHAN_W  = 8;
   localparam int TEXEL_W = 4 * CHAN_W;
   localparam int PROD_W  = COORD_W + CFG_W;
   localparam int ROW_W   = 2 * CFG_W;
   localparam int SUM_W   = ROW_W + 1;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic [CHAN_W-1:0] NOIMG_RED   = 8'd255;
   localparam logic [CHAN_W-1:0] NOIMG_GREEN = 8'd0;
   localparam logic [CHAN_W-1:0] NOIMG_BLUE  = 8'd255;
   localparam logic [CHAN_W-1:0] NOIMG_ALPHA = 8'd255;

endpackage

[rtl/bilinear_texture_sampler_wrap.sv]
// Bilinear texture sampler with wrap addressing, top level.
//
// Requests enter on the req_ channel (valid/stall). A write request
// (action 0) stores one RGBA texel at a linear address below capped width*height;
// other writes are dropped. A sample request (action 1) returns one
// blended RGBA result on the rsp_ channel. Writes return nothing.
// Width and height are set through the APB port; the user must set them only
// while the block is idle (not enforced); a zero side makes every sample
// return magenta. Requests are accepted one per cycle while not stalled.
// A sample result is registered through input multiply, wrap and weight, row
// multiply, texture read (four RAM copies, one per neighbor), horizontal
// blend, vertical blend and rounding into the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset clears the valid bits and both size registers; the
// texture contents stay undefined until written.
module bilinear_texture_sampler_wrap #(
   parameter int MAX_SIDE    = 256,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [15:0]                  req_texel_address,
   input  logic [bts_pkg::CHAN_W-1:0]   req_write_red,
   input  logic [bts_pkg::CHAN_W-1:0]   req_write_green,
   input  logic [bts_pkg::CHAN_W-1:0]   req_write_blue,
   input  logic [bts_pkg::CHAN_W-1:0]   req_write_alpha,
   input  logic [bts_pkg::COORD_W-1:0]  req_u_coord,
   input  logic [bts_pkg::COORD_W-1:0]  req_v_coord,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bts_pkg::CHAN_W-1:0]   rsp_out_red,
   output logic [bts_pkg::CHAN_W-1:0]   rsp_out_green,
   output logic [bts_pkg::CHAN_W-1:0]   rsp_out_blue,
   output logic [bts_pkg::CHAN_W-1:0]   rsp_out_alpha,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   import bts_pkg::*;

   localparam int AW   = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int WB   = WEIGHT_BITS;
   localparam int TW   = CHAN_W + WB + 1;
   localparam int OW   = CHAN_W + 2 * WB + 1;
   localparam int ONE  = 1 << WB;

   // configuration
   logic [CFG_W-1:0] width_ff, height_ff;
   logic [CFG_W-1:0] side_w, side_h;
   logic             cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (cfg_wr) begin
         case (reg_index_type'(paddr[2]))
            REG_WIDTH:  width_ff  <= pwdata[CFG_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[2]))
         REG_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, width_ff};
         REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, height_ff};
         default:    prdata = '0;
      endcase
   end

   assign side_w = (width_ff  > MAX_SIDE) ? CFG_W'(MAX_SIDE) : width_ff;
   assign side_h = (height_ff > MAX_SIDE) ? CFG_W'(MAX_SIDE) : height_ff;

   logic             noimg;
   logic [ROW_W-1:0] area;
   assign noimg = (side_w == '0) || (side_h == '0);
   assign area  = ROW_W'(side_w) * ROW_W'(side_h);

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage 1: coordinate multiply
   logic               s1_vld_ff, s1_act_ff, s1_noimg_ff;
   logic [15:0]        s1_addr_ff;
   logic [TEXEL_W-1:0] s1_data_ff;
   logic [PROD_W-1:0]  s1_px_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_act_ff   <= req_action;
         s1_noimg_ff <= noimg;
         s1_addr_ff  <= req_texel_address;
         s1_data_ff  <= {req_write_alpha, req_write_blue, req_write_green, req_write_red};
         s1_px_ff    <= PROD_W'(req_u_coord) * PROD_W'(side_w);
         s1_py_ff    <= PROD_W'(req_v_coord) * PROD_W'(side_h);
      end
   end

   // stage 2: wrap indexes and weights
   function automatic logic [CFG_W-1:0] base_idx(input logic [PROD_W-1:0] p,
                                                 input logic [CFG_W-1:0]  side);
      logic [CFG_W-1:0] hi;
      hi = p[PROD_W-1:COORD_W];
      if (p[COORD_W-1]) begin
         return hi;
      end else if (hi == '0) begin
         return side - CFG_W'(1);
      end
      return hi - CFG_W'(1);
   endfunction

   function automatic logic [CFG_W-1:0] next_idx(input logic [CFG_W-1:0] a,
                                                 input logic [CFG_W-1:0] side);
      logic [CFG_W-1:0] n;
      n = a + CFG_W'(1);
      return (n == side) ? '0 : n;
   endfunction

   logic [CFG_W-1:0] x0_c, y0_c;
   logic [15:0]      fx_c, fy_c;
   assign x0_c = base_idx(s1_px_ff, side_w);
   assign y0_c = base_idx(s1_py_ff, side_h);
   assign fx_c = {~s1_px_ff[15], s1_px_ff[14:0]};
   assign fy_c = {~s1_py_ff[15], s1_py_ff[14:0]};

   logic               s2_vld_ff, s2_act_ff, s2_noimg_ff, s2_we_ff;
   logic [15:0]        s2_addr_ff;
   logic [TEXEL_W-1:0] s2_data_ff;
   logic [CFG_W-1:0]   s2_x0_ff, s2_x1_ff, s2_y0_ff, s2_y1_ff;
   logic [WB-1:0]      s2_wx_ff, s2_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_act_ff   <= s1_act_ff;
         s2_noimg_ff <= s1_noimg_ff;
         s2_we_ff    <= s1_vld_ff && (s1_act_ff == ACT_WRITE) &&
                        ({{(ROW_W-16){1'b0}}, s1_addr_ff} < area);
         s2_addr_ff  <= s1_addr_ff;
         s2_data_ff  <= s1_data_ff;
         s2_x0_ff    <= x0_c;
         s2_x1_ff    <= next_idx(x0_c, side_w);
         s2_y0_ff    <= y0_c;
         s2_y1_ff    <= next_idx(y0_c, side_h);
         s2_wx_ff    <= fx_c[15 -: WB];
         s2_wy_ff    <= fy_c[15 -: WB];
      end
   end

   // stage 3: row offsets
   logic                 s3_vld_ff, s3_act_ff, s3_noimg_ff, s3_we_ff;
   logic [AW-1:0]        s3_waddr_ff;
   logic [TEXEL_W-1:0]   s3_data_ff;
   logic [CFG_W-1:0]     s3_x0_ff, s3_x1_ff;
   logic [ROW_W-1:0]     s3_r0_ff, s3_r1_ff;
   logic [WB-1:0]        s3_wx_ff, s3_wy_ff;
   logic [AW+15:0]       waddr_ext;

   assign waddr_ext = {{AW{1'b0}}, s2_addr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
         s3_we_ff  <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
         s3_we_ff  <= s2_vld_ff && s2_we_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_act_ff   <= s2_act_ff;
         s3_noimg_ff <= s2_noimg_ff;
         s3_waddr_ff <= waddr_ext[AW-1:0];
         s3_data_ff  <= s2_data_ff;
         s3_x0_ff    <= s2_x0_ff;
         s3_x1_ff    <= s2_x1_ff;
         s3_r0_ff    <= ROW_W'(s2_y0_ff) * ROW_W'(side_w);
         s3_r1_ff    <= ROW_W'(s2_y1_ff) * ROW_W'(side_w);
         s3_wx_ff    <= s2_wx_ff;
         s3_wy_ff    <= s2_wy_ff;
      end
   end

   // stage 4: texture read and write, one RAM copy per neighbor
   logic [SUM_W-1:0]   sum_c   [4];
   logic [AW+SUM_W-1:0] sum_ext [4];
   logic [AW-1:0]      rd_addr [4];
   logic [TEXEL_W-1:0] rd_data [4];

   assign sum_c[0] = SUM_W'(s3_r0_ff) + SUM_W'(s3_x0_ff);
   assign sum_c[1] = SUM_W'(s3_r0_ff) + SUM_W'(s3_x1_ff);
   assign sum_c[2] = SUM_W'(s3_r1_ff) + SUM_W'(s3_x0_ff);
   assign sum_c[3] = SUM_W'(s3_r1_ff) + SUM_W'(s3_x1_ff);

   for (genvar g = 0; g < 4; g++) begin : g_ram
      assign sum_ext[g] = {{AW{1'b0}}, sum_c[g]};
      assign rd_addr[g] = sum_ext[g][AW-1:0];
      bts_ram #(
         .WIDTH (TEXEL_W),
         .DEPTH (MAX_SIDE * MAX_SIDE)
      ) u_ram (
         .clock   (clock),
         .wr_en   (adv && s3_we_ff),
         .wr_addr (s3_waddr_ff),
         .wr_data (s3_data_ff),
         .rd_en   (adv),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   logic          s4_vld_ff, s4_act_ff, s4_noimg_ff;
   logic [WB-1:0] s4_wx_ff, s4_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_act_ff   <= s3_act_ff;
         s4_noimg_ff <= s3_noimg_ff;
         s4_wx_ff    <= s3_wx_ff;
         s4_wy_ff    <= s3_wy_ff;
      end
   end

   // stage 5: horizontal blend
   logic [WB:0]   wxc, wyc;
   logic [TW-1:0] top_c [4];
   logic [TW-1:0] bot_c [4];

   assign wxc = (WB+1)'(ONE) - {1'b0, s4_wx_ff};

   for (genvar c = 0; c < 4; c++) begin : g_hblend
      assign top_c[c] = TW'(rd_data[0][CHAN_W*c +: CHAN_W]) * TW'(wxc) +
                        TW'(rd_data[1][CHAN_W*c +: CHAN_W]) * TW'(s4_wx_ff);
      assign bot_c[c] = TW'(rd_data[2][CHAN_W*c +: CHAN_W]) * TW'(wxc) +
                        TW'(rd_data[3][CHAN_W*c +: CHAN_W]) * TW'(s4_wx_ff);
   end

   logic          s5_vld_ff, s5_act_ff, s5_noimg_ff;
   logic [WB-1:0] s5_wy_ff;
   logic [TW-1:0] s5_top_ff [4];
   logic [TW-1:0] s5_bot_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_act_ff   <= s4_act_ff;
         s5_noimg_ff <= s4_noimg_ff;
         s5_wy_ff    <= s4_wy_ff;
         s5_top_ff   <= top_c;
         s5_bot_ff   <= bot_c;
      end
   end

   // stage 6: vertical blend, round, output register
   logic [OW-1:0]     vsum_c [4];
   logic [CHAN_W-1:0] chan_c [4];

   assign wyc = (WB+1)'(ONE) - {1'b0, s5_wy_ff};

   for (genvar c = 0; c < 4; c++) begin : g_vblend
      assign vsum_c[c] = OW'(s5_top_ff[c]) * OW'(wyc) +
                         OW'(s5_bot_ff[c]) * OW'(s5_wy_ff) +
                         (OW'(1) << (2 * WB - 1));
      assign chan_c[c] = vsum_c[c][2*WB +: CHAN_W];
   end

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s5_vld_ff && (s5_act_ff == ACT_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s5_noimg_ff) begin
            rsp_red_ff   <= NOIMG_RED;
            rsp_green_ff <= NOIMG_GREEN;
            rsp_blue_ff  <= NOIMG_BLUE;
            rsp_alpha_ff <= NOIMG_ALPHA;
         end else begin
            rsp_red_ff   <= chan_c[0];
            rsp_green_ff <= chan_c[1];
            rsp_blue_ff  <= chan_c[2];
            rsp_alpha_ff <= chan_c[3];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(s5_vld_ff) && $stable(s4_vld_ff)))
      else $error("pipeline moved while output stalled");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (s3_we_ff && !s3_noimg_ff) |-> ({{(ROW_W+16-AW){1'b0}}, s3_waddr_ff} <
                                     {{(AW){1'b0}}, area}))
      else $error("texel write beyond image");

   a_write_needs_image: assert property (@(posedge clock) disable iff (reset)
      s3_we_ff |-> !s3_noimg_ff)
      else $error("texel write with no image");

   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && !s2_noimg_ff && (s2_act_ff == ACT_SAMPLE)) |->
      ((s2_x0_ff < side_w) && (s2_x1_ff < side_w) &&
       (s2_y0_ff < side_h) && (s2_y1_ff < side_h)))
      else $error("wrapped index out of range");

endmodule

[rtl/bts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/bilinear_texture_sampler_wrap_tb.sv]
// Testbench for the bilinear texture sampler: texture writes, samples and size settings.
module bilinear_texture_sampler_wrap_tb;
   import bts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      action_type  act;
      logic [15:0] addr;
      logic [7:0]  red, green, blue, alpha;
      logic [15:0] u, v;
   } request_type;

   typedef struct {
      logic [7:0] red, green, blue, alpha;
   } rgba_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = ACT_WRITE;
   logic [15:0] req_texel_address = '0;
   logic [7:0] req_write_red = '0, req_write_green = '0, req_write_blue = '0;
   logic [7:0] req_write_alpha = '0;
   logic [15:0] req_u_coord = '0, req_v_coord = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   logic [31:0] texture_mem [65536];
   bit written_map [65536];
   logic [8:0] image_width, image_height;
   rgba_type pending_colors[$];
   int errors = 0;
   bit calm = 1'b0;
   int stall_left = 0;

   bilinear_texture_sampler_wrap uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("FAIL bilinear_texture_sampler_wrap");
      $finish;
   end

   function automatic int side_of(logic [8:0] s);
      return (s > 256) ? 256 : int'(s);
   endfunction

   function automatic void wrap_axis(input logic [15:0] coord, input int side,
                                     output int i0, output int i1, output int wt);
      longint t;
      t = longint'(coord) * side + (longint'(side) << 16) - 32768;
      i0 = int'((t >> 16) % side);
      i1 = (i0 + 1) % side;
      wt = int'((t & 'hFFFF) >> 8);
   endfunction

   function automatic rgba_type blend_sample(logic [15:0] u, logic [15:0] v);
      rgba_type c;
      int w, h, x0, x1, y0, y1, wx, wy;
      longint a, b, cc, d, top, bot, sum;
      logic [7:0] ch [4];
      w = side_of(image_width);
      h = side_of(image_height);
      if (w == 0 || h == 0) begin
         c.red = NOIMG_RED; c.green = NOIMG_GREEN;
         c.blue = NOIMG_BLUE; c.alpha = NOIMG_ALPHA;
         return c;
      end
      wrap_axis(u, w, x0, x1, wx);
      wrap_axis(v, h, y0, y1, wy);
      for (int k = 0; k < 4; k++) begin
         a = (texture_mem[y0 * w + x0] >> (8 * k)) & 'hFF;
         b = (texture_mem[y0 * w + x1] >> (8 * k)) & 'hFF;
         cc = (texture_mem[y1 * w + x0] >> (8 * k)) & 'hFF;
         d = (texture_mem[y1 * w + x1] >> (8 * k)) & 'hFF;
         top = a * (256 - wx) + b * wx;
         bot = cc * (256 - wx) + d * wx;
         sum = top * (256 - wy) + bot * wy + 32768;
         ch[k] = 8'(sum >> 16);
      end
      c.red = ch[0]; c.green = ch[1]; c.blue = ch[2]; c.alpha = ch[3];
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 10);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rgba_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h %h %h %h", $realtime, rsp_out_red,
                     rsp_out_green, rsp_out_blue, rsp_out_alpha);
         end else begin
            e = pending_colors.pop_front();
            if (rsp_out_red !== e.red) begin
               errors++;
               $display("%0t: red expected %h actual %h", $realtime, e.red, rsp_out_red);
            end
            if (rsp_out_green !== e.green) begin
               errors++;
               $display("%0t: green expected %h actual %h", $realtime, e.green,
                        rsp_out_green);
            end
            if (rsp_out_blue !== e.blue) begin
               errors++;
               $display("%0t: blue expected %h actual %h", $realtime, e.blue, rsp_out_blue);
            end
            if (rsp_out_alpha !== e.alpha) begin
               errors++;
               $display("%0t: alpha expected %h actual %h", $realtime, e.alpha,
                        rsp_out_alpha);
            end
         end
      end
   end

   task automatic send_request(request_type r);
      bit taken;
      int gap;
      req_valid <= 1'b1;
      req_action <= r.act;
      req_texel_address <= r.addr;
      req_write_red <= r.red;
      req_write_green <= r.green;
      req_write_blue <= r.blue;
      req_write_alpha <= r.alpha;
      req_u_coord <= r.u;
      req_v_coord <= r.v;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      if (r.act == ACT_SAMPLE) begin
         pending_colors = {pending_colors, blend_sample(r.u, r.v)};
      end else if (int'(r.addr) < side_of(image_width) * side_of(image_height)) begin
         texture_mem[r.addr] = {r.alpha, r.blue, r.green, r.red};
         written_map[r.addr] = 1'b1;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_write(int addr, logic [31:0] color);
      request_type r;
      r.act = ACT_WRITE; r.addr = 16'(addr);
      {r.alpha, r.blue, r.green, r.red} = color;
      r.u = 16'($urandom); r.v = 16'($urandom);
      send_request(r);
   endtask

   task automatic send_sample(logic [15:0] u, logic [15:0] v);
      request_type r;
      r.act = ACT_SAMPLE; r.addr = 16'($urandom);
      {r.alpha, r.blue, r.green, r.red} = $urandom;
      r.u = u; r.v = v;
      send_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [8:0] value);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= 3'(idx) << 2;
      pwdata <= {23'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == REG_WIDTH) image_width = value;
      else image_height = value;
   endtask

   task automatic set_size(logic [8:0] w, logic [8:0] h);
      wait_drained();
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
   endtask

   task automatic fill_texture();
      for (int a = 0; a < side_of(image_width) * side_of(image_height); a++)
         if (!written_map[a]) send_write(a, $urandom);
   endtask

   task automatic random_traffic(int count);
      int area;
      area = side_of(image_width) * side_of(image_height);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 70) send_sample(16'($urandom), 16'($urandom));
         else if (area > 0 && $urandom_range(3) != 0)
            send_write($urandom_range(area - 1), $urandom);
         else send_write($urandom_range(65535), $urandom);
      end
   endtask

   task automatic test_no_image();
      send_sample(16'h0000, 16'h0000);
      send_write(0, 32'hFFFF_FFFF);
      send_sample(16'hFFFF, 16'h8000);
      set_size(9'd0, 9'd4);
      send_sample(16'h1234, 16'hFFFF);
      set_size(9'd4, 9'd0);
      send_write(1, 32'h0);
      send_sample(16'hFFFF, 16'h0000);
   endtask

   task automatic test_corners();
      set_size(9'd2, 9'd2);
      send_write(0, 32'h0000_0000);
      send_write(1, 32'hFFFF_FFFF);
      send_write(2, 32'hFF00_FF00);
      send_write(3, 32'h00FF_00FF);
      send_write(4, 32'hFFFF_FFFF);
      send_write(65535, 32'h1234_5678);
      foreach (written_map[a]) begin
         if (a > 3 && written_map[a]) begin
            errors++;
            $display("%0t: texel %0d stored expected 0 actual 1", $realtime, a);
         end
      end
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'h4000, 16'h4000);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'hC000, 16'h4000);
      send_sample(16'h0001, 16'hFFFE);
      send_sample(16'h7FFF, 16'h3FFF);
   endtask

   task automatic test_size_sweep();
      set_size(9'd3, 9'd5);
      fill_texture();
      random_traffic(120);
      wait_drained();
      random_traffic(60);
      set_size(9'd256, 9'd2);
      fill_texture();
      random_traffic(120);
      set_size(9'd1, 9'd256);
      fill_texture();
      random_traffic(120);
      set_size(9'd511, 9'd1);
      fill_texture();
      random_traffic(80);
      set_size(9'd1, 9'd1);
      random_traffic(60);
      set_size(9'd1, 9'd511);
      random_traffic(60);
   endtask

   task automatic test_random_sizes();
      for (int p = 0; p < 4; p++) begin
         set_size(9'($urandom_range(16, 1)), 9'($urandom_range(16, 1)));
         calm = (p == 2);
         fill_texture();
         random_traffic(20);
      end
      calm = 1'b0;
      set_size(9'd0, 9'd0);
      random_traffic(40);
   endtask

   initial begin
      int wait_cycles;
      image_width = '0;
      image_height = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_image();
      test_corners();
      test_size_sweep();
      test_random_sizes();
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_colors.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_colors.size() == 0) begin
         $display("PASS bilinear_texture_sampler_wrap");
      end else begin
         $display("FAIL bilinear_texture_sampler_wrap");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bilinear_texture_sampler_wrap.sv
bench/bilinear_texture_sampler_wrap_tb.sv
